// ===== src/spsl_pkg.sv =====
// shared types, constants and the quarter-wave sine table of the sine position servo
package spsl_pkg;

  // encoder and trajectory geometry
  localparam int COUNTS_PER_TURN = 8192;
  localparam int ANGLE_W         = $clog2(COUNTS_PER_TURN);
  localparam int DELTA_W         = ANGLE_W + 2;
  localparam int SINE_DEPTH      = 256;  // power of two
  localparam int SINE_IDX_W      = $clog2(SINE_DEPTH);
  localparam int SINE_W          = 16;

  // field widths
  localparam int ACT_W    = 2;
  localparam int FID_W    = 11;
  localparam int AMP_W    = 13;
  localparam int PHASE_W  = 32;
  localparam int CYC_W    = 16;
  localparam int GAIN_W   = 16;
  localparam int WORD_W   = 16;
  localparam int TEMP_W   = 8;
  localparam int TGT_W    = 14;
  localparam int MTA_W    = 32;
  localparam int DRIVE_W  = 16;

  // multiplier operands: clamped error or amplitude, and zero-extended gain or table entry
  localparam int ERR_W       = 26;
  localparam int ERR_FULL_W  = MTA_W + 1;
  localparam int OPB_W       = GAIN_W + 1;
  localparam int PROD_W      = ERR_W + OPB_W;
  localparam int GAIN_SHIFT  = 10;
  localparam int ROUND_SHIFT = 15;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // stream payload widths
  localparam int IN_USER_W  = ACT_W;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_USER_W = 1;
  localparam int OUT_DATA_W = 120;
  localparam int OUT_USED_W = DRIVE_W + TGT_W + MTA_W + ANGLE_W + 2 * WORD_W + TEMP_W + 1;

  // input tdata field offsets
  localparam int IN_FID_LSB   = 0;
  localparam int IN_ANGLE_LSB = IN_FID_LSB + FID_W;
  localparam int IN_SPD_LSB   = IN_ANGLE_LSB + ANGLE_W;
  localparam int IN_TRQ_LSB   = IN_SPD_LSB + WORD_W;
  localparam int IN_TMP_LSB   = IN_TRQ_LSB + WORD_W;

  // reset values of the registers
  localparam logic [FID_W-1:0]   RST_FEEDBACK_ID = FID_W'(517);
  localparam logic [AMP_W-1:0]   RST_AMPLITUDE   = AMP_W'(569);
  localparam logic [PHASE_W-1:0] RST_PHASE_STEP  = PHASE_W'(17179869);
  localparam logic [CYC_W-1:0]   RST_CYCLE_LIMIT = CYC_W'(2000);
  localparam logic [GAIN_W-1:0]  RST_LOOP_GAIN   = GAIN_W'(9000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FEEDBACK_ID = 3'd0,
    REG_AMPLITUDE   = 3'd1,
    REG_PHASE_STEP  = 3'd2,
    REG_CYCLE_LIMIT = 3'd3,
    REG_LOOP_GAIN   = 3'd4
  } cfg_reg_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_FEEDBACK = 2'd0,
    ACT_TICK     = 2'd1,
    ACT_START    = 2'd2
  } action_t;

  typedef enum logic {
    MUL_SINE = 1'b0,
    MUL_GAIN = 1'b1
  } mul_sel_t;

  typedef struct packed {
    logic     en;
    mul_sel_t sel;
  } mul_req_t;

  // table build: Q30 odd polynomial of degree 9, evaluated at elaboration
  localparam longint Q30 = 64'sd1 << 30;
  localparam longint K1  = 64'sd1686629713;
  localparam longint K3  = 64'sd693598668;
  localparam longint K5  = 64'sd85569306;
  localparam longint K7  = 64'sd5026994;
  localparam longint K9  = 64'sd172272;

  typedef logic [SINE_W-1:0] sine_rom_t [SINE_DEPTH];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    longint    t;
    longint    t2;
    longint    p;
    longint    v;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      t  = ((2 * longint'(i) + 1) * (Q30 / 2)) / SINE_DEPTH;
      t2 = (t * t) / Q30;
      p  = K9;
      p  = (p * t2) / Q30 - K7;
      p  = (p * t2) / Q30 + K5;
      p  = (p * t2) / Q30 - K3;
      p  = (p * t2) / Q30 + K1;
      p  = (p * t) / Q30;
      if (p < 0) p = 0;
      v = (p * 32767 + Q30 / 2) / Q30;
      if (v > 32767) v = 32767;
      rom[i] = v[SINE_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== src/spsl_sine_rom.sv =====
// quarter-wave sine lookup with quadrant mirroring and registered read
module spsl_sine_rom (
  input  logic                        clk,
  input  logic                        en,
  input  logic [spsl_pkg::PHASE_W-1:0] phase,
  output logic [spsl_pkg::SINE_W-1:0]  entry_r,
  output logic                        neg_r
);
  import spsl_pkg::*;

  logic [SINE_IDX_W-1:0] idx;

  // index is the top bits of the phase within its quarter
  always_comb begin
    idx = phase[PHASE_W-3 -: SINE_IDX_W];
    if (phase[PHASE_W-2]) idx = ~idx;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      entry_r <= SINE_ROM[idx];
      neg_r   <= phase[PHASE_W-1];
    end
  end

endmodule

// ===== src/spsl_mul.sv =====
// shared signed multiplier with operand select and registered product
module spsl_mul (
  input  logic                              clk,
  input  spsl_pkg::mul_req_t                req,
  input  logic [spsl_pkg::AMP_W-1:0]        amp,
  input  logic [spsl_pkg::SINE_W-1:0]       entry,
  input  logic signed [spsl_pkg::ERR_W-1:0] err,
  input  logic [spsl_pkg::GAIN_W-1:0]       gain,
  output logic signed [spsl_pkg::PROD_W-1:0] prod_r
);
  import spsl_pkg::*;

  logic signed [ERR_W-1:0] op_a;
  logic signed [OPB_W-1:0] op_b;

  always_comb begin
    case (req.sel)
      MUL_SINE: begin
        op_a = $signed({{(ERR_W-AMP_W){1'b0}}, amp});
        op_b = $signed({{(OPB_W-SINE_W){1'b0}}, entry});
      end
      MUL_GAIN: begin
        op_a = err;
        op_b = $signed({{(OPB_W-GAIN_W){1'b0}}, gain});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (req.en) prod_r <= op_a * op_b;
  end

endmodule

// ===== src/sine_position_servo_loop_top.sv =====
// top level of the sine position servo: state, sequencer and stream ports
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in_     | slave     | in_tvalid/tready   | tuser action, tdata feedback fields
//  out_    | master    | out_tvalid/tready  | tuser drive_valid, tdata drive and status
//  cfg_    | slave     | cfg_valid/ready    | cfg_index register, cfg_data value
//
// feedback, start, unknown and idle-tick items go from accept through decode
// to result; a tick while running steps through lookup, sine multiply, target
// round, error clamp, gain multiply and result, both multiplies through the one
// shared multiplier; the final stop tick skips sine multiply and target round
// in_tready is high only in the idle state; one item is in work at a time
// a result waits in the output register, a stalled output holds the
// sequencer in its last step until the transaction completes
// rst_n is synchronous; cfg_ready is always high
module sine_position_servo_loop_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [spsl_pkg::IN_USER_W-1:0]      in_tuser,  // action
  // frame_id, angle_raw, speed_word, torque_word, temperature_byte
  input  logic [spsl_pkg::IN_DATA_W-1:0]      in_tdata,
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [spsl_pkg::OUT_USER_W-1:0]     out_tuser, // drive_valid
  // drive_value, target_counts, cumulative_counts, last_angle, last_speed,
  // last_torque, last_temperature, trajectory_active, zero pad
  output logic [spsl_pkg::OUT_DATA_W-1:0]     out_tdata,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [spsl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [spsl_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import spsl_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECODE = 6'b000010,
    ST_MSINE  = 6'b000100,
    ST_TARGET = 6'b001000,
    ST_ERR    = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  localparam logic signed [DELTA_W-1:0] HALF_TURN = DELTA_W'(COUNTS_PER_TURN / 2);
  localparam logic signed [DELTA_W-1:0] FULL_TURN = DELTA_W'(COUNTS_PER_TURN);
  localparam logic signed [ERR_FULL_W-1:0] ERR_MAX = ERR_FULL_W'((64'sd1 <<< (ERR_W - 1)) - 1);
  localparam logic signed [ERR_FULL_W-1:0] ERR_MIN = -ERR_FULL_W'(64'sd1 <<< (ERR_W - 1));
  localparam int Q_W = PROD_W - GAIN_SHIFT;
  localparam logic signed [Q_W-1:0] DRIVE_MAX = Q_W'(32767);
  localparam logic signed [Q_W-1:0] DRIVE_MIN = -Q_W'(32768);
  localparam logic signed [PROD_W-1:0] TRUNC_BIAS = PROD_W'((1 << GAIN_SHIFT) - 1);
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (ROUND_SHIFT - 1));

  // sequencer
  state_t state_r, state_nxt;

  // configuration registers
  logic [FID_W-1:0]   feedback_id_r;
  logic [AMP_W-1:0]   amplitude_r;
  logic [PHASE_W-1:0] phase_step_r;
  logic [CYC_W-1:0]   cycle_limit_r;
  logic [GAIN_W-1:0]  loop_gain_r;

  // servo state
  logic [ANGLE_W-1:0] prev_angle_r, prev_angle_nxt;
  logic [MTA_W-1:0]   mta_r, mta_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [CYC_W-1:0]   cycles_r, cycles_nxt;
  logic               running_r, running_nxt;
  logic [WORD_W-1:0]  speed_r, speed_nxt;
  logic [WORD_W-1:0]  torque_r, torque_nxt;
  logic [TEMP_W-1:0]  temp_r, temp_nxt;

  // captured item
  logic [ACT_W-1:0]   act_r;
  logic [FID_W-1:0]   fid_r;
  logic [ANGLE_W-1:0] angle_in_r;
  logic [WORD_W-1:0]  speed_in_r;
  logic [WORD_W-1:0]  torque_in_r;
  logic [TEMP_W-1:0]  temp_in_r;

  // working registers
  logic                    drv_en_r, drv_en_nxt;
  logic signed [TGT_W-1:0] target_r, target_nxt;
  logic signed [ERR_W-1:0] err_r, err_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_USER_W-1:0] out_user_r, out_user_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // shared units
  mul_req_t                 mul_req;
  mul_req_t                 mul_req_q;
  logic                     rom_en;
  logic [SINE_W-1:0]        rom_entry;
  logic                     rom_neg;
  logic signed [PROD_W-1:0] prod;

  // gain product is taken in the cycle after the error clamp
  logic mgain_r;
  logic mul_gain_go;

  // combinational helpers
  logic signed [DELTA_W-1:0]    delta;
  logic [PHASE_W:0]             phase_sum;
  logic                         run_ok;
  logic signed [PROD_W-1:0]     mag_full;
  logic signed [TGT_W-1:0]      mag;
  logic signed [ERR_FULL_W-1:0] err_full;
  logic signed [PROD_W-1:0]     prod_adj;
  logic signed [Q_W-1:0]        quot;
  logic signed [DRIVE_W-1:0]    drive;
  logic                         out_free;

  spsl_sine_rom u_rom (
    .clk     (clk),
    .en      (rom_en),
    .phase   (phase_r),
    .entry_r (rom_entry),
    .neg_r   (rom_neg)
  );

  spsl_mul u_mul (
    .clk    (clk),
    .req    (mul_req_q),
    .amp    (amplitude_r),
    .entry  (rom_entry),
    .err    (err_r),
    .gain   (loop_gain_r),
    .prod_r (prod)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  // angle step folded into half a turn either way
  always_comb begin
    delta = $signed({2'b00, angle_in_r}) - $signed({2'b00, prev_angle_r});
    if (delta > HALF_TURN) delta = delta - FULL_TURN;
    else if (delta < -HALF_TURN) delta = delta + FULL_TURN;
  end

  assign phase_sum = {1'b0, phase_r} + {1'b0, phase_step_r};
  assign run_ok    = running_r && (cycles_r < cycle_limit_r);

  // target magnitude rounded from the sine product
  always_comb begin
    mag_full = (prod + ROUND_HALF) >>> ROUND_SHIFT;
    mag      = mag_full[TGT_W-1:0];
  end

  // error clamped so the gain product stays narrow; the clamp never changes
  // the saturated drive
  always_comb begin
    err_full = $signed({{(ERR_FULL_W-TGT_W){target_r[TGT_W-1]}}, target_r})
             - $signed({mta_r[MTA_W-1], mta_r});
    if (err_full > ERR_MAX) err_nxt = ERR_MAX[ERR_W-1:0];
    else if (err_full < ERR_MIN) err_nxt = ERR_MIN[ERR_W-1:0];
    else err_nxt = err_full[ERR_W-1:0];
  end

  // divide by 1024 toward zero, then saturate
  always_comb begin
    prod_adj = (prod < 0) ? prod + TRUNC_BIAS : prod;
    quot     = Q_W'(prod_adj >>> GAIN_SHIFT);
    if (quot > DRIVE_MAX) drive = DRIVE_MAX[DRIVE_W-1:0];
    else if (quot < DRIVE_MIN) drive = DRIVE_MIN[DRIVE_W-1:0];
    else drive = quot[DRIVE_W-1:0];
  end

  always_comb begin
    state_nxt      = state_r;
    prev_angle_nxt = prev_angle_r;
    mta_nxt        = mta_r;
    phase_nxt      = phase_r;
    cycles_nxt     = cycles_r;
    running_nxt    = running_r;
    speed_nxt      = speed_r;
    torque_nxt     = torque_r;
    temp_nxt       = temp_r;
    drv_en_nxt     = drv_en_r;
    target_nxt     = target_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_user_nxt   = out_user_r;
    out_data_nxt   = out_data_r;
    rom_en         = 1'b0;
    mul_req.en     = 1'b0;
    mul_req.sel    = MUL_SINE;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        drv_en_nxt = 1'b0;
        target_nxt = '0;
        state_nxt  = ST_EMIT;
        case (act_r)
          ACT_FEEDBACK: begin
            if (fid_r == feedback_id_r) begin
              mta_nxt        = mta_r + {{(MTA_W-DELTA_W){delta[DELTA_W-1]}}, delta};
              prev_angle_nxt = angle_in_r;
              speed_nxt      = speed_in_r;
              torque_nxt     = torque_in_r;
              temp_nxt       = temp_in_r;
            end
          end
          ACT_TICK: begin
            // lookup uses the phase before this tick advances it
            rom_en      = 1'b1;
            drv_en_nxt  = running_r;
            running_nxt = run_ok;
            phase_nxt   = phase_sum[PHASE_W-1:0];
            if (run_ok && phase_sum[PHASE_W] && (cycles_r != '1))
              cycles_nxt = cycles_r + CYC_W'(1);
            if (run_ok) state_nxt = ST_MSINE;
            else if (running_r) state_nxt = ST_ERR;  // final drive, target zero
          end
          ACT_START: begin
            phase_nxt   = '0;
            cycles_nxt  = '0;
            running_nxt = 1'b1;
          end
          default: begin
          end
        endcase
      end
      ST_MSINE: begin
        mul_req.en  = 1'b1;
        mul_req.sel = MUL_SINE;
        state_nxt   = ST_TARGET;
      end
      ST_TARGET: begin
        target_nxt = rom_neg ? -mag : mag;
        state_nxt  = ST_ERR;
      end
      ST_ERR: begin
        // err_r loads here, gain product follows in the next step
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = drv_en_r;
          out_data_nxt  = {{(OUT_DATA_W-OUT_USED_W){1'b0}}, running_r, temp_r, torque_r,
                           speed_r, prev_angle_r, mta_r, target_r,
                           drv_en_r ? drive : {DRIVE_W{1'b0}}};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      mgain_r       <= 1'b0;
      feedback_id_r <= RST_FEEDBACK_ID;
      amplitude_r   <= RST_AMPLITUDE;
      phase_step_r  <= RST_PHASE_STEP;
      cycle_limit_r <= RST_CYCLE_LIMIT;
      loop_gain_r   <= RST_LOOP_GAIN;
      prev_angle_r  <= '0;
      mta_r         <= '0;
      phase_r       <= '0;
      cycles_r      <= '0;
      running_r     <= 1'b0;
      speed_r       <= '0;
      torque_r      <= '0;
      temp_r        <= '0;
      drv_en_r      <= 1'b0;
    end else begin
      // the gain multiply holds the sequencer in err while it runs
      state_r       <= (state_r == ST_ERR || mgain_r) && !mgain_r ? state_r : state_nxt;
      mgain_r       <= (state_r == ST_ERR) && !mgain_r;
      out_valid_r   <= out_valid_nxt && !((state_r == ST_EMIT) && mgain_r);
      prev_angle_r  <= prev_angle_nxt;
      mta_r         <= mta_nxt;
      phase_r       <= phase_nxt;
      cycles_r      <= cycles_nxt;
      running_r     <= running_nxt;
      speed_r       <= speed_nxt;
      torque_r      <= torque_nxt;
      temp_r        <= temp_nxt;
      drv_en_r      <= drv_en_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FEEDBACK_ID: feedback_id_r <= cfg_data[FID_W-1:0];
          REG_AMPLITUDE:   amplitude_r   <= cfg_data[AMP_W-1:0];
          REG_PHASE_STEP:  phase_step_r  <= cfg_data[PHASE_W-1:0];
          REG_CYCLE_LIMIT: cycle_limit_r <= cfg_data[CYC_W-1:0];
          REG_LOOP_GAIN:   loop_gain_r   <= cfg_data[GAIN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    target_r   <= target_nxt;
    out_user_r <= out_user_nxt;
    out_data_r <= out_data_nxt;
    if (state_r == ST_ERR && !mgain_r) err_r <= err_nxt;
    if (in_tvalid && in_tready) begin
      act_r       <= in_tuser;
      fid_r       <= in_tdata[IN_FID_LSB +: FID_W];
      angle_in_r  <= in_tdata[IN_ANGLE_LSB +: ANGLE_W];
      speed_in_r  <= in_tdata[IN_SPD_LSB +: WORD_W];
      torque_in_r <= in_tdata[IN_TRQ_LSB +: WORD_W];
      temp_in_r   <= in_tdata[IN_TMP_LSB +: TEMP_W];
    end
  end

  // drive the gain multiply from the step flag
  assign mul_gain_go = mgain_r;

  // shared multiplier request: sine step from the sequencer, gain step from the flag
  always_comb begin
    mul_req_q = mul_req;
    if (mul_gain_go) begin
      mul_req_q.en  = 1'b1;
      mul_req_q.sel = MUL_GAIN;
    end
  end

endmodule

// ===== src/spsl_checker.sv =====
// port-level checker for the sine position servo top, bound to the top level
module spsl_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [spsl_pkg::OUT_USER_W-1:0]  out_tuser,
  input logic [spsl_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import spsl_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in work");

  // no drive means zero drive and zero target
  a_no_drive_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[DRIVE_W+TGT_W-1:0] == '0)
    else $error("drive fields set without a drive");

  // after reset the block is idle and empty
  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid && in_tready)
    else $error("block not idle after reset");

endmodule

bind sine_position_servo_loop_top spsl_checker u_spsl_checker (.*);

// ===== dv/tb_sine_position_servo_loop_top.sv =====
// self-checking testbench for the sine position servo: directed and random stimulus against a local predictor
module tb_sine_position_servo_loop_top;
  import spsl_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int WATCHDOG_LIMIT = 3000;
  // quiet time after the drain, with margin over a running tick
  localparam int SETTLE_CYCLES  = 12;
  localparam int QUARTER_DEPTH  = 256;

  // action code the block does not know
  localparam logic [ACT_W-1:0] ACT_UNKNOWN = 2'd3;

  // result tdata layout, lowest bit first
  localparam int O_DRIVE_LSB  = 0;
  localparam int O_TGT_LSB    = O_DRIVE_LSB + DRIVE_W;
  localparam int O_CUM_LSB    = O_TGT_LSB + TGT_W;
  localparam int O_ANGLE_LSB  = O_CUM_LSB + MTA_W;
  localparam int O_SPD_LSB    = O_ANGLE_LSB + ANGLE_W;
  localparam int O_TRQ_LSB    = O_SPD_LSB + WORD_W;
  localparam int O_TMP_LSB    = O_TRQ_LSB + WORD_W;
  localparam int O_ACTIVE_LSB = O_TMP_LSB + TEMP_W;

  // Q30 coefficients of the odd degree-9 sine polynomial
  localparam longint POLY_ONE = 64'sd1 << 30;
  localparam longint POLY_K1  = 64'sd1686629713;
  localparam longint POLY_K3  = 64'sd693598668;
  localparam longint POLY_K5  = 64'sd85569306;
  localparam longint POLY_K7  = 64'sd5026994;
  localparam longint POLY_K9  = 64'sd172272;

  typedef struct {
    logic               drive_valid;
    logic [DRIVE_W-1:0] drive;
    logic [TGT_W-1:0]   target;
    logic [MTA_W-1:0]   cumulative;
    logic [ANGLE_W-1:0] angle;
    logic [WORD_W-1:0]  speed;
    logic [WORD_W-1:0]  torque;
    logic [TEMP_W-1:0]  temp;
    logic               active;
  } servo_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_USER_W-1:0]  in_tuser;   // action
  // frame_id, angle_raw, speed_word, torque_word, temperature_byte
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_USER_W-1:0] out_tuser;  // drive_valid
  // drive_value, target_counts, cumulative_counts, last_angle, last_speed,
  // last_torque, last_temperature, trajectory_active, zero pad
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // local copy of the servo registers, at their reset values
  logic [FID_W-1:0]   reg_feedback_id = RST_FEEDBACK_ID;
  logic [AMP_W-1:0]   reg_amplitude   = RST_AMPLITUDE;
  logic [PHASE_W-1:0] reg_phase_step  = RST_PHASE_STEP;
  logic [CYC_W-1:0]   reg_cycle_limit = RST_CYCLE_LIMIT;
  logic [GAIN_W-1:0]  reg_loop_gain   = RST_LOOP_GAIN;

  // local copy of the servo state, reset to zero
  logic [ANGLE_W-1:0] pos_prev_angle = '0;
  logic [MTA_W-1:0]   turns_count    = '0;
  logic [PHASE_W-1:0] sine_phase     = '0;
  logic [CYC_W-1:0]   wraps_done     = '0;
  logic               traj_on        = 1'b0;
  logic [WORD_W-1:0]  held_speed     = '0;
  logic [WORD_W-1:0]  held_torque    = '0;
  logic [TEMP_W-1:0]  held_temp      = '0;
  int                 sine_quarter [QUARTER_DEPTH];

  servo_report_t servo_reports [$];

  int  mismatches     = 0;
  int  items_sent     = 0;
  int  starts_sent    = 0;
  int  reg_writes     = 0;
  int  drives_seen    = 0;
  int  finals_seen    = 0;
  int  stalled_cycles = 0;
  int  stall_left     = 0;
  // when set, neither side inserts gaps or stalls
  logic quiet = 1'b0;

  sine_position_servo_loop_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // quarter-wave table, sin(pi/2*(i+0.5)/depth) scaled to 32767
  function automatic void build_sine_quarter();
    longint t;
    longint t2;
    longint p;
    longint v;
    for (int i = 0; i < QUARTER_DEPTH; i++) begin
      t  = ((2 * longint'(i) + 1) * (POLY_ONE / 2)) / QUARTER_DEPTH;
      t2 = (t * t) / POLY_ONE;
      p  = POLY_K9;
      p  = (p * t2) / POLY_ONE - POLY_K7;
      p  = (p * t2) / POLY_ONE + POLY_K5;
      p  = (p * t2) / POLY_ONE - POLY_K3;
      p  = (p * t2) / POLY_ONE + POLY_K1;
      p  = (p * t) / POLY_ONE;
      if (p < 0) p = 0;
      v = (p * 32767 + POLY_ONE / 2) / POLY_ONE;
      if (v > 32767) v = 32767;
      sine_quarter[i] = int'(v);
    end
  endfunction

  // trajectory target at the current phase, in encoder counts
  function automatic int sine_target_counts();
    logic [1:0] quadrant;
    int         idx;
    int         mag;
    quadrant = sine_phase[31:30];
    idx      = int'(sine_phase[29:22]);
    if (quadrant[0]) idx = QUARTER_DEPTH - 1 - idx;
    mag = (int'(reg_amplitude) * sine_quarter[idx] + 16384) >>> 15;
    return quadrant[1] ? -mag : mag;
  endfunction

  // advances the local servo state by one transaction and returns its report
  function automatic servo_report_t predict_servo_report(
    logic [ACT_W-1:0]   act,
    logic [FID_W-1:0]   fid,
    logic [ANGLE_W-1:0] ang,
    logic [WORD_W-1:0]  spd,
    logic [WORD_W-1:0]  trq,
    logic [TEMP_W-1:0]  tmp
  );
    servo_report_t      rep;
    int                 delta;
    int                 target;
    longint             err;
    longint             drv;
    logic [PHASE_W-1:0] next_phase;
    rep.drive_valid = 1'b0;
    target = 0;
    drv    = 0;
    case (act)
      ACT_FEEDBACK: begin
        if (fid == reg_feedback_id) begin
          delta = int'(ang) - int'(pos_prev_angle);
          // fold steps beyond half a turn, exactly half a turn stays
          if (delta > COUNTS_PER_TURN / 2) delta -= COUNTS_PER_TURN;
          else if (delta < -(COUNTS_PER_TURN / 2)) delta += COUNTS_PER_TURN;
          turns_count    = turns_count + MTA_W'(delta);
          pos_prev_angle = ang;
          held_speed     = spd;
          held_torque    = trq;
          held_temp      = tmp;
        end
      end
      ACT_TICK: begin
        if (traj_on) begin
          rep.drive_valid = 1'b1;
          if (wraps_done < reg_cycle_limit) begin
            target = sine_target_counts();
          end else begin
            target  = 0;
            traj_on = 1'b0;
          end
          err = longint'(target) - longint'($signed(turns_count));
          drv = (err * longint'(reg_loop_gain)) / 1024;
          if (drv > 32767) drv = 32767;
          if (drv < -32768) drv = -32768;
        end
        // the phase runs on even when idle, wraps count only while running
        next_phase = sine_phase + reg_phase_step;
        if (traj_on && next_phase < sine_phase && wraps_done != {CYC_W{1'b1}})
          wraps_done = wraps_done + 1'b1;
        sine_phase = next_phase;
      end
      ACT_START: begin
        sine_phase = '0;
        wraps_done = '0;
        traj_on    = 1'b1;
      end
      default: begin
      end
    endcase
    rep.drive      = drv[DRIVE_W-1:0];
    rep.target     = target[TGT_W-1:0];
    rep.cumulative = turns_count;
    rep.angle      = pos_prev_angle;
    rep.speed      = held_speed;
    rep.torque     = held_torque;
    rep.temp       = held_temp;
    rep.active     = traj_on;
    return rep;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // mostly back to back, sometimes a short gap, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // result side back-pressure, same mix of short and long stalls
  always @(negedge clk) begin : ready_gen
    int r;
    r = $urandom_range(0, 99);
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (quiet || r < 70) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b0;
      stall_left <= (r < 96) ? $urandom_range(0, 3) : $urandom_range(15, 40);
    end
  end

  // compare every result transaction with the oldest pending report
  always @(posedge clk) begin : result_check
    servo_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (servo_reports.size() == 0) begin
        $error("result transaction with no pending report");
        mismatches++;
      end else begin
        want = servo_reports.pop_front();
        check_field("drive_valid", want.drive_valid, out_tuser[0]);
        check_field("drive_value", want.drive, out_tdata[O_DRIVE_LSB +: DRIVE_W]);
        check_field("target_counts", want.target, out_tdata[O_TGT_LSB +: TGT_W]);
        check_field("cumulative_counts", want.cumulative, out_tdata[O_CUM_LSB +: MTA_W]);
        check_field("last_angle", want.angle, out_tdata[O_ANGLE_LSB +: ANGLE_W]);
        check_field("last_speed", want.speed, out_tdata[O_SPD_LSB +: WORD_W]);
        check_field("last_torque", want.torque, out_tdata[O_TRQ_LSB +: WORD_W]);
        check_field("last_temperature", want.temp, out_tdata[O_TMP_LSB +: TEMP_W]);
        check_field("trajectory_active", want.active, out_tdata[O_ACTIVE_LSB]);
        check_field("pad", '0, 32'(out_tdata[OUT_DATA_W-1:O_ACTIVE_LSB+1]));
        if (out_tuser[0]) begin
          drives_seen++;
          if (!out_tdata[O_ACTIVE_LSB]) finals_seen++;
        end
      end
    end
  end

  // watchdog: too long without any transaction on any channel ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  // one input transaction; starts and ends at a falling edge, in_tvalid is
  // left high after the accept and lowered by the next gap or by settle
  task automatic send_item(
    input logic [ACT_W-1:0]   act,
    input logic [FID_W-1:0]   fid,
    input logic [ANGLE_W-1:0] ang,
    input logic [WORD_W-1:0]  spd,
    input logic [WORD_W-1:0]  trq,
    input logic [TEMP_W-1:0]  tmp
  );
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  <= act;
    in_tdata  <= {tmp, trq, spd, ang, fid};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    servo_reports.push_back(predict_servo_report(act, fid, ang, spd, trq, tmp));
    items_sent++;
    if (act == ACT_START) starts_sent++;
    @(negedge clk);
  endtask

  // feedback or other item with random speed, torque and temperature
  task automatic send_random_fields(input logic [ACT_W-1:0] act, input logic [FID_W-1:0] fid,
                                    input logic [ANGLE_W-1:0] ang);
    send_item(act, fid, ang, WORD_W'($urandom()), WORD_W'($urandom()), TEMP_W'($urandom()));
  endtask

  task automatic send_tick();
    send_random_fields(ACT_TICK, FID_W'($urandom()), ANGLE_W'($urandom()));
  endtask

  task automatic send_start();
    send_random_fields(ACT_START, FID_W'($urandom()), ANGLE_W'($urandom()));
  endtask

  // drop the input at once so the last item is not taken again, wait until
  // every pending report has arrived, then let the block go quiet
  task automatic settle(input int cycles);
    in_tvalid <= 1'b0;
    while (servo_reports.size() != 0) @(posedge clk);
    @(negedge clk);
    repeat (cycles) @(negedge clk);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_FEEDBACK_ID: reg_feedback_id = value[FID_W-1:0];
      REG_AMPLITUDE:   reg_amplitude   = value[AMP_W-1:0];
      REG_PHASE_STEP:  reg_phase_step  = value[PHASE_W-1:0];
      REG_CYCLE_LIMIT: reg_cycle_limit = value[CYC_W-1:0];
      REG_LOOP_GAIN:   reg_loop_gain   = value[GAIN_W-1:0];
      default: begin
      end
    endcase
    reg_writes++;
    @(negedge clk);
  endtask

  // all five registers, written only with the block idle
  task automatic apply_settings(
    input logic [FID_W-1:0]   fid,
    input logic [AMP_W-1:0]   amp,
    input logic [PHASE_W-1:0] step,
    input logic [CYC_W-1:0]   limit,
    input logic [GAIN_W-1:0]  gain
  );
    settle(SETTLE_CYCLES);
    write_register(REG_FEEDBACK_ID, CFG_DATA_W'(fid));
    write_register(REG_AMPLITUDE, CFG_DATA_W'(amp));
    write_register(REG_PHASE_STEP, CFG_DATA_W'(step));
    write_register(REG_CYCLE_LIMIT, CFG_DATA_W'(limit));
    write_register(REG_LOOP_GAIN, CFG_DATA_W'(gain));
    cfg_valid <= 1'b0;
  endtask

  // small walks mostly, sometimes right at, just short of or just past half a turn, else a random angle
  function automatic logic [ANGLE_W-1:0] next_angle();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return pos_prev_angle + ANGLE_W'($urandom_range(0, 600)) - ANGLE_W'(300);
    if (r == 7) return pos_prev_angle + ANGLE_W'(COUNTS_PER_TURN / 2);
    if (r == 8) return pos_prev_angle + ANGLE_W'($urandom_range(0, 1) ? 4097 : 4095);
    return ANGLE_W'($urandom());
  endfunction

  // unwrap across the turn boundary, half-turn steps, extreme feedback words,
  // frames for other ids
  task automatic test_feedback_unwrap();
    send_item(ACT_FEEDBACK, reg_feedback_id, 13'd0, 16'h7fff, 16'h8000, 8'h80);
    send_item(ACT_FEEDBACK, reg_feedback_id, 13'd4096, 16'h8000, 16'h7fff, 8'h7f);
    send_random_fields(ACT_FEEDBACK, reg_feedback_id, 13'd8191);
    send_random_fields(ACT_FEEDBACK, reg_feedback_id, 13'd0);
    send_random_fields(ACT_FEEDBACK, reg_feedback_id, 13'd4097);
    send_random_fields(ACT_FEEDBACK, reg_feedback_id, 13'd1);
    send_random_fields(ACT_FEEDBACK, reg_feedback_id - 1'b1, 13'd3000);
    send_item(ACT_FEEDBACK, 11'h7ff, 13'h1fff, 16'hffff, 16'hffff, 8'hff);
  endtask

  // unknown action, idle tick, start and restart, stop with a zero cycle limit
  task automatic test_trajectory_control();
    send_random_fields(ACT_UNKNOWN, FID_W'($urandom()), ANGLE_W'($urandom()));
    send_tick();
    send_start();
    repeat (3) send_tick();
    send_random_fields(ACT_FEEDBACK, reg_feedback_id, pos_prev_angle + 13'd100);
    send_tick();
    send_start();
    send_tick();
    apply_settings(RST_FEEDBACK_ID, RST_AMPLITUDE, RST_PHASE_STEP, '0, RST_LOOP_GAIN);
    send_start();
    send_tick();
    send_tick();
  endtask

  // quarter-turn phase steps with full amplitude and gain drive the output
  // into both saturation limits, then a run with everything at zero
  task automatic test_register_extremes();
    apply_settings(11'h7ff, 13'h1fff, 32'h4000_0000, 16'd1, 16'hffff);
    send_random_fields(ACT_FEEDBACK, 11'h7ff, pos_prev_angle);
    send_random_fields(ACT_FEEDBACK, RST_FEEDBACK_ID, 13'd2000);
    send_start();
    repeat (6) send_tick();
    apply_settings('0, '0, '0, '0, '0);
    send_random_fields(ACT_FEEDBACK, 11'h000, pos_prev_angle + 13'd7);
    send_start();
    repeat (2) send_tick();
  endtask

  // trajectories with random feedback in between, under several settings
  task automatic test_random_trajectories();
    int                 useful;
    int                 r;
    logic [FID_W-1:0]   other_fid;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: apply_settings(RST_FEEDBACK_ID, RST_AMPLITUDE, 32'h1000_0000, 16'd3, RST_LOOP_GAIN);
        1: apply_settings(11'h000, 13'h1fff, 32'hffff_ffff, 16'hffff, 16'hffff);
        2: apply_settings(11'h7ff, 13'h0000, 32'h0000_0000, 16'd0, 16'd0);
        3: apply_settings(FID_W'($urandom()), AMP_W'($urandom()),
                          $urandom_range(32'h0400_0000, 32'h4000_0000),
                          CYC_W'($urandom_range(0, 4)), GAIN_W'($urandom()));
        4: apply_settings(FID_W'($urandom()), AMP_W'($urandom()),
                          $urandom_range(32'h0800_0000, 32'hffff_ffff),
                          CYC_W'($urandom_range(0, 8)), GAIN_W'($urandom()));
        default: apply_settings(FID_W'($urandom()), 13'h1fff, 32'h7fff_ffff, 16'd2, 16'd1);
      endcase
      useful = 0;
      while (useful < 175) begin
        if (useful % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (r < 5 || (!traj_on && r < 30)) begin
          send_start();
          useful++;
        end else if (r < 60) begin
          send_tick();
          useful++;
        end else if (r < 92) begin
          send_random_fields(ACT_FEEDBACK, reg_feedback_id, next_angle());
          useful++;
        end else if (r < 96) begin
          // a frame for some other id, must be dropped
          other_fid = reg_feedback_id ^ FID_W'($urandom_range(1, 2047));
          send_random_fields(ACT_FEEDBACK, other_fid, ANGLE_W'($urandom()));
        end else begin
          send_random_fields(ACT_UNKNOWN, FID_W'($urandom()), ANGLE_W'($urandom()));
        end
      end
      quiet = 1'b0;
    end
  endtask

  initial begin
    build_sine_quarter();
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = '0;
    in_tdata   = '0;
    out_tready = 1'b1;
    cfg_valid  = 1'b0;
    cfg_index  = REG_FEEDBACK_ID;
    cfg_data   = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_feedback_unwrap();
    test_trajectory_control();
    test_register_extremes();
    test_random_trajectories();

    // drain, then watch a little longer for stray results
    settle(2 * SETTLE_CYCLES);
    $display("covered %0d input transactions (%0d starts) and %0d register writes",
             items_sent, starts_sent, reg_writes);
    $display("checked %0d drive commands, %0d of them final stops", drives_seen, finals_seen);
    if (mismatches == 0 && servo_reports.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
